/* rtl/tla_pkg.sv */
// Shared types and constants for the temperature limit alarm.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package tla_pkg;

	localparam int unsigned ACT_W    = 3;
	localparam int unsigned RAW_W    = 16;
	localparam int unsigned DEG_W    = 7;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned TENTHS_W = 10;
	localparam int unsigned PERIOD_W = 8;

	// input action codes
	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEC    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_INC    = 3'd4;

	localparam logic [TENTHS_W-1:0] TENTHS_MAX  = 10'd999;
	localparam logic [DEG_W-1:0]    LIMIT_MAX   = 7'd99;
	localparam logic [DEG_W-1:0]    UPPER_RESET = 7'd30;
	localparam logic [DEG_W-1:0]    LOWER_RESET = 7'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;

	// reciprocal of ten: floor(x * 205 / 2048) == floor(x / 10) for x below 1029
	localparam logic [7:0] RECIP_TEN  = 8'd205;
	localparam int unsigned RECIP_SHIFT = 11;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_TICK,
		CMD_SAMPLE,
		CMD_SET,
		CMD_DEC,
		CMD_INC
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_RUN       = 2'd0,
		MODE_SET_UPPER = 2'd1,
		MODE_SET_LOWER = 2'd2
	} mode_t;

	// one classified beat waiting between front and back
	typedef struct packed {
		cmd_t                cmd;
		logic [TENTHS_W-1:0] tenths;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// result beat, last field in the lowest bits
	typedef struct packed {
		logic               limit_visible;
		logic               alarm_on;
		logic [DEG_W-1:0]   lower_out;
		logic [DEG_W-1:0]   upper_out;
		logic [DIGIT_W-1:0] temp_tenth;
		logic [DEG_W-1:0]   temp_whole;
		mode_t              mode;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/tla_front.sv */
// Front end: decode the action of an input beat and convert a raw sample to clamped tenths.
// Depends on tla_pkg.
`default_nettype none

module tla_front (
	input  wire logic [tla_pkg::ACT_W-1:0] action,
	input  wire logic [tla_pkg::RAW_W-1:0] raw_sample,
	output tla_pkg::entry_t                entry
);

	logic signed [20:0] raw_ext;
	logic signed [20:0] num;
	logic        [15:0] quot;
	tla_pkg::cmd_t      cmd;
	logic [tla_pkg::TENTHS_W-1:0] tenths;

	always_comb begin
		unique case (action)
			tla_pkg::ACT_TICK:   cmd = tla_pkg::CMD_TICK;
			tla_pkg::ACT_SAMPLE: cmd = tla_pkg::CMD_SAMPLE;
			tla_pkg::ACT_SET:    cmd = tla_pkg::CMD_SET;
			tla_pkg::ACT_DEC:    cmd = tla_pkg::CMD_DEC;
			tla_pkg::ACT_INC:    cmd = tla_pkg::CMD_INC;
			default:             cmd = tla_pkg::CMD_NONE;
		endcase
	end

	// raw*10 + 8, then floor divide by 16 as a shift; clamp to 0..999
	always_comb begin
		raw_ext = $signed({{5{raw_sample[15]}}, raw_sample});
		num     = (raw_ext <<< 3) + (raw_ext <<< 1) + 21'sd8;
		quot    = num[19:4];
		if (num[20]) begin
			tenths = '0;
		end else if (quot > 16'(tla_pkg::TENTHS_MAX)) begin
			tenths = tla_pkg::TENTHS_MAX;
		end else begin
			tenths = quot[tla_pkg::TENTHS_W-1:0];
		end
	end

	assign entry.cmd    = cmd;
	assign entry.tenths = tenths;

endmodule

`default_nettype wire

/* rtl/tla_queue.sv */
// Short FIFO of classified beats between the front end and the back end.
// Depends on tla_pkg.
`default_nettype none

module tla_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire tla_pkg::entry_t push_entry,
	input  wire logic        pop,
	output tla_pkg::entry_t  head,
	output tla_pkg::q_status_t status
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	tla_pkg::entry_t   slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/tla_back.sv */
// Back end: apply queued commands to the alarm state and hold the result beat.
// Depends on tla_pkg.
`default_nettype none

module tla_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [tla_pkg::PERIOD_W-1:0]  tick_period,
	input  wire tla_pkg::entry_t               head,
	input  wire tla_pkg::q_status_t            q_status,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output tla_pkg::result_t                   result
);

	tla_pkg::mode_t                    mode_q, mode_d;
	logic [tla_pkg::DEG_W-1:0]         upper_q, upper_d;
	logic [tla_pkg::DEG_W-1:0]         lower_q, lower_d;
	logic [tla_pkg::PERIOD_W-1:0]      tick_cnt_q, tick_cnt_d;
	logic [tla_pkg::PERIOD_W-1:0]      tick_inc;
	logic                              beep_q, beep_d;
	logic                              blink_q, blink_d;
	logic [tla_pkg::DEG_W-1:0]         whole_q, whole_d;
	logic [tla_pkg::DIGIT_W-1:0]       tenth_q, tenth_d;
	logic [17:0]                       recip_prod;
	logic [tla_pkg::DEG_W-1:0]         conv_whole;
	logic [10:0]                       whole_x10;
	logic [tla_pkg::TENTHS_W-1:0]      conv_rem;
	tla_pkg::result_t                  res_d;
	tla_pkg::result_t                  out_q;
	logic                              out_valid_q;

	assign pop = !q_status.empty && (!out_valid_q || out_ready);

	// split tenths into whole degrees and the tenths digit
	always_comb begin
		recip_prod = 18'(head.tenths) * 18'(tla_pkg::RECIP_TEN);
		conv_whole = recip_prod[tla_pkg::RECIP_SHIFT +: tla_pkg::DEG_W];
		whole_x10  = (11'(conv_whole) << 3) + (11'(conv_whole) << 1);
		conv_rem   = head.tenths - whole_x10[tla_pkg::TENTHS_W-1:0];
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		upper_d    = upper_q;
		lower_d    = lower_q;
		tick_cnt_d = tick_cnt_q;
		beep_d     = beep_q;
		blink_d    = blink_q;
		whole_d    = whole_q;
		tenth_d    = tenth_q;
		tick_inc   = tick_cnt_q + 1'b1;
		unique case (head.cmd)
			tla_pkg::CMD_TICK: begin
				if (tick_inc >= tick_period) begin
					tick_cnt_d = '0;
					if (mode_q == tla_pkg::MODE_RUN) begin
						beep_d = !beep_q;
					end else begin
						blink_d = !blink_q;
					end
				end else begin
					tick_cnt_d = tick_inc;
				end
			end
			tla_pkg::CMD_SAMPLE: begin
				whole_d = conv_whole;
				tenth_d = conv_rem[tla_pkg::DIGIT_W-1:0];
			end
			tla_pkg::CMD_SET: begin
				unique case (mode_q)
					tla_pkg::MODE_RUN:       mode_d = tla_pkg::MODE_SET_UPPER;
					tla_pkg::MODE_SET_UPPER: mode_d = tla_pkg::MODE_SET_LOWER;
					default:                 mode_d = tla_pkg::MODE_RUN;
				endcase
				tick_cnt_d = '0;
				blink_d    = 1'b1;
			end
			tla_pkg::CMD_DEC: begin
				if (mode_q == tla_pkg::MODE_SET_UPPER) begin
					upper_d = (upper_q > lower_q) ? upper_q - 1'b1 : lower_q;
				end else if (mode_q == tla_pkg::MODE_SET_LOWER) begin
					lower_d = (lower_q == '0) ? '0 : lower_q - 1'b1;
				end
			end
			tla_pkg::CMD_INC: begin
				if (mode_q == tla_pkg::MODE_SET_UPPER) begin
					upper_d = (upper_q >= tla_pkg::LIMIT_MAX) ? tla_pkg::LIMIT_MAX
					                                         : upper_q + 1'b1;
				end else if (mode_q == tla_pkg::MODE_SET_LOWER) begin
					lower_d = (lower_q >= upper_q) ? upper_q : lower_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result from the updated state
	always_comb begin
		res_d.mode          = mode_d;
		res_d.temp_whole    = whole_d;
		res_d.temp_tenth    = tenth_d;
		res_d.upper_out     = upper_d;
		res_d.lower_out     = lower_d;
		res_d.alarm_on      = (mode_d == tla_pkg::MODE_RUN) && beep_d &&
		                      ((whole_d >= upper_d) || (whole_d < lower_d));
		res_d.limit_visible = (mode_d != tla_pkg::MODE_RUN) && blink_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tla_pkg::MODE_RUN;
			upper_q     <= tla_pkg::UPPER_RESET;
			lower_q     <= tla_pkg::LOWER_RESET;
			tick_cnt_q  <= '0;
			beep_q      <= 1'b0;
			blink_q     <= 1'b0;
			whole_q     <= '0;
			tenth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q     <= mode_d;
				upper_q    <= upper_d;
				lower_q    <= lower_d;
				tick_cnt_q <= tick_cnt_d;
				beep_q     <= beep_d;
				blink_q    <= blink_d;
				whole_q    <= whole_d;
				tenth_q    <= tenth_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

`default_nettype wire

/* rtl/temperature_limit_alarm.sv */
// Top level of the temperature limit alarm: stream ports, tick period register, three parts.
// Depends on tla_pkg, tla_front, tla_queue and tla_back.
`default_nettype none

// Each input beat is a tick, a temperature sample or a key press, and each
// produces exactly one result beat showing the display and alarm state after
// it. A sample is converted to tenths of a degree and clamped to 0.0..99.9;
// the set key steps the mode run, set-upper, set-lower; the decrement and
// increment keys move the limit being set, keeping 0 <= lower <= upper <= 99.
// The front end decodes and converts the beat in the cycle it is taken and
// drops it into a QUEUE_DEPTH-entry FIFO; the back end pops one entry per
// cycle unless the output is stalled, updates the state and loads the output
// register. One beat per cycle is sustained while m_axis_tready is high; a
// beat passes the FIFO write, then the back-end update into the output
// register. s_axis_tready falls only while the FIFO is full. Write tick_period
// through the cfg channel only while no beat is in flight; it is always ready.

module temperature_limit_alarm #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input beats
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [15:0]                        s_axis_tdata,  // [15:0] raw_sample
	input  wire logic [7:0]                         s_axis_tuser,  // [2:0] action
	// result beats
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [1:0] mode, [8:2] temp_whole, [12:9] temp_tenth, [19:13] upper_out,
	// [26:20] lower_out, [27] alarm_on, [28] limit_visible, [31:29] zero
	output logic [tla_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// tick_period register write
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [tla_pkg::PERIOD_W-1:0]       cfg_data
);

	tla_pkg::entry_t     front_entry;
	tla_pkg::entry_t     q_head;
	tla_pkg::q_status_t  q_status;
	tla_pkg::result_t    result;
	logic                q_pop;
	logic                in_beat;
	logic [tla_pkg::PERIOD_W-1:0] tick_period_q;

	// tick period: take every write at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= tla_pkg::PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_period_q <= cfg_data;
		end
	end

	// hold input off only while the FIFO is full
	assign s_axis_tready = !q_status.full;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	tla_front u_front (
		.action     (s_axis_tuser[tla_pkg::ACT_W-1:0]),
		.raw_sample (s_axis_tdata),
		.entry      (front_entry)
	);

	tla_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_beat),
		.push_entry (front_entry),
		.pop        (q_pop),
		.head       (q_head),
		.status     (q_status)
	);

	tla_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_period (tick_period_q),
		.head        (q_head),
		.q_status    (q_status),
		.pop         (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.result      (result)
	);

	// pad the result to whole bytes
	assign m_axis_tdata = {{(tla_pkg::OUT_TDATA_W - tla_pkg::RESULT_W){1'b0}}, result};

	// limits keep their order on every shown beat
	a_limit_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (result.lower_out <= result.upper_out))
		else $error("lower limit above upper limit");

	// the alarm sounds only in run mode
	a_alarm_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result.alarm_on) |-> (result.mode == tla_pkg::MODE_RUN))
		else $error("alarm outside run mode");

	// the blinking limit shows only while setting
	a_blink_set: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result.limit_visible) |-> (result.mode != tla_pkg::MODE_RUN))
		else $error("limit shown in run mode");

	// a popped entry always becomes a shown result in the next cycle
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_axis_tvalid)
		else $error("popped entry not presented");

	// FIFO never claims full and empty together
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue status inconsistent");

endmodule

`default_nettype wire
